>>> hw/rtl/acs_pkg.sv
// ----------------------------------------------------------------------------
// acs_pkg
// Shared types, codes and the microprogram for the accumulator cpu step block.
// ----------------------------------------------------------------------------
`default_nettype none

package acs_pkg;

  localparam int ADDR_W    = 8;
  localparam int ADDR_SPAN = 2 ** ADDR_W;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_READ   = 2'd1,
    KIND_EXEC   = 2'd2,
    KIND_REGRST = 2'd3
  } kind_t;

  typedef enum logic [7:0] {
    OP_LDA  = 8'd0,
    OP_LDB  = 8'd1,
    OP_LDM  = 8'd2,
    OP_STA  = 8'd3,
    OP_ADD  = 8'd4,
    OP_SUB  = 8'd5,
    OP_OUT  = 8'd6,
    OP_OUTC = 8'd7,
    OP_JNZ  = 8'd8,
    OP_JZ   = 8'd9,
    OP_JMP  = 8'd10,
    OP_AND  = 8'd11,
    OP_OR   = 8'd12,
    OP_XOR  = 8'd13,
    OP_SHL  = 8'd14,
    OP_SHR  = 8'd15,
    OP_NOT  = 8'd16,
    OP_INC  = 8'd17,
    OP_DEC  = 8'd18,
    OP_CMP  = 8'd19,
    OP_HLT  = 8'd20
  } op_t;

  // micro addresses
  typedef enum logic [4:0] {
    U_WR, U_RD0, U_RD1, U_RST, U_EX0, U_EX1, U_EX2,
    U_LDA, U_LDB, U_LDM0, U_LDM1, U_STA, U_ADD, U_SUB, U_OUT, U_OUTC,
    U_JNZ, U_JZ, U_JMP, U_AND, U_OR, U_XOR, U_SHL, U_SHR, U_NOT,
    U_INC, U_DEC, U_CMP, U_HLT, U_DONE
  } upc_t;

  typedef enum logic [1:0] {SEQ_GOTO, SEQ_JHALT, SEQ_DISPATCH, SEQ_DONE} seq_t;
  typedef enum logic [1:0] {ASEL_PC, ASEL_PC1, ASEL_ARG, ASEL_REQ} asel_t;
  typedef enum logic {WSEL_REQ, WSEL_ACC} wsel_t;
  typedef enum logic [1:0] {EMIT_NONE, EMIT_NUM, EMIT_CHAR} emit_t;

  typedef enum logic [2:0] {
    PC_KEEP, PC_STEP1, PC_STEP2, PC_JUMP, PC_JZ, PC_JNZ
  } pcsel_t;

  typedef enum logic [3:0] {
    ALU_ARG, ALU_MEM, ALU_ADD, ALU_SUB, ALU_AND, ALU_OR, ALU_XOR,
    ALU_SHL, ALU_SHR, ALU_NOT, ALU_INC, ALU_DEC, ALU_CMP, ALU_TEST
  } alu_t;

  typedef struct packed {
    seq_t   seq;
    upc_t   nxt;
    asel_t  asel;
    logic   mem_we;
    wsel_t  wsel;
    logic   ir_ld;
    logic   arg_ld;
    logic   rd_ld;
    alu_t   alu;
    logic   acc_ld;
    logic   zero_ld;
    logic   carry_ld;
    logic   b_ld;
    pcsel_t pc_sel;
    emit_t  emit;
    logic   halt_set;
    logic   regs_clr;
  } ctrl_t;

  typedef struct packed {
    logic [7:0] rd;
    emit_t      emit;
    logic       halt;
    logic [7:0] pc;
    logic [7:0] acc;
    logic       zf;
    logic       cf;
  } stat_t;

  localparam ctrl_t CTRL_NOP = '{
    seq: SEQ_GOTO, nxt: U_DONE, asel: ASEL_PC, mem_we: 1'b0, wsel: WSEL_REQ,
    ir_ld: 1'b0, arg_ld: 1'b0, rd_ld: 1'b0, alu: ALU_TEST, acc_ld: 1'b0,
    zero_ld: 1'b0, carry_ld: 1'b0, b_ld: 1'b0, pc_sel: PC_KEEP,
    emit: EMIT_NONE, halt_set: 1'b0, regs_clr: 1'b0
  };

  // microprogram rom
  function automatic ctrl_t ucode(upc_t u);
    ctrl_t w;
    w = CTRL_NOP;
    unique case (u)
      U_WR: begin
        w.asel = ASEL_REQ; w.mem_we = 1'b1; w.wsel = WSEL_REQ;
      end
      U_RD0: begin
        w.asel = ASEL_REQ; w.nxt = U_RD1;
      end
      U_RD1: w.rd_ld = 1'b1;
      U_RST: w.regs_clr = 1'b1;
      U_EX0: begin
        w.seq = SEQ_JHALT; w.nxt = U_EX1; w.asel = ASEL_PC;
      end
      U_EX1: begin
        w.asel = ASEL_PC1; w.ir_ld = 1'b1; w.nxt = U_EX2;
      end
      U_EX2: begin
        w.arg_ld = 1'b1; w.seq = SEQ_DISPATCH;
      end
      U_LDA: begin
        w.alu = ALU_ARG; w.acc_ld = 1'b1; w.zero_ld = 1'b1; w.pc_sel = PC_STEP2;
      end
      U_LDB: begin
        w.b_ld = 1'b1; w.pc_sel = PC_STEP2;
      end
      U_LDM0: begin
        w.asel = ASEL_ARG; w.nxt = U_LDM1;
      end
      U_LDM1: begin
        w.alu = ALU_MEM; w.acc_ld = 1'b1; w.zero_ld = 1'b1; w.pc_sel = PC_STEP2;
      end
      U_STA: begin
        w.asel = ASEL_ARG; w.mem_we = 1'b1; w.wsel = WSEL_ACC; w.pc_sel = PC_STEP2;
      end
      U_ADD: begin
        w.alu = ALU_ADD; w.acc_ld = 1'b1; w.zero_ld = 1'b1; w.carry_ld = 1'b1;
        w.pc_sel = PC_STEP1;
      end
      U_SUB: begin
        w.alu = ALU_SUB; w.acc_ld = 1'b1; w.zero_ld = 1'b1; w.carry_ld = 1'b1;
        w.pc_sel = PC_STEP1;
      end
      U_OUT: begin
        w.emit = EMIT_NUM; w.pc_sel = PC_STEP1;
      end
      U_OUTC: begin
        w.emit = EMIT_CHAR; w.pc_sel = PC_STEP1;
      end
      U_JNZ: begin
        w.alu = ALU_TEST; w.zero_ld = 1'b1; w.pc_sel = PC_JNZ;
      end
      U_JZ:  w.pc_sel = PC_JZ;
      U_JMP: w.pc_sel = PC_JUMP;
      U_AND: begin
        w.alu = ALU_AND; w.acc_ld = 1'b1; w.zero_ld = 1'b1; w.pc_sel = PC_STEP1;
      end
      U_OR: begin
        w.alu = ALU_OR; w.acc_ld = 1'b1; w.zero_ld = 1'b1; w.pc_sel = PC_STEP1;
      end
      U_XOR: begin
        w.alu = ALU_XOR; w.acc_ld = 1'b1; w.zero_ld = 1'b1; w.pc_sel = PC_STEP1;
      end
      U_SHL: begin
        w.alu = ALU_SHL; w.acc_ld = 1'b1; w.zero_ld = 1'b1; w.carry_ld = 1'b1;
        w.pc_sel = PC_STEP1;
      end
      U_SHR: begin
        w.alu = ALU_SHR; w.acc_ld = 1'b1; w.zero_ld = 1'b1; w.carry_ld = 1'b1;
        w.pc_sel = PC_STEP1;
      end
      U_NOT: begin
        w.alu = ALU_NOT; w.acc_ld = 1'b1; w.zero_ld = 1'b1; w.pc_sel = PC_STEP1;
      end
      U_INC: begin
        w.alu = ALU_INC; w.acc_ld = 1'b1; w.zero_ld = 1'b1; w.carry_ld = 1'b1;
        w.pc_sel = PC_STEP1;
      end
      U_DEC: begin
        w.alu = ALU_DEC; w.acc_ld = 1'b1; w.zero_ld = 1'b1; w.pc_sel = PC_STEP1;
      end
      U_CMP: begin
        w.alu = ALU_CMP; w.zero_ld = 1'b1; w.pc_sel = PC_STEP1;
      end
      U_HLT:  w.halt_set = 1'b1;
      U_DONE: w.seq = SEQ_DONE;
      default: w = CTRL_NOP;
    endcase
    return w;
  endfunction

  // opcode to micro routine
  function automatic upc_t dispatch(logic [7:0] op);
    upc_t u;
    unique case (op)
      OP_LDA:  u = U_LDA;
      OP_LDB:  u = U_LDB;
      OP_LDM:  u = U_LDM0;
      OP_STA:  u = U_STA;
      OP_ADD:  u = U_ADD;
      OP_SUB:  u = U_SUB;
      OP_OUT:  u = U_OUT;
      OP_OUTC: u = U_OUTC;
      OP_JNZ:  u = U_JNZ;
      OP_JZ:   u = U_JZ;
      OP_JMP:  u = U_JMP;
      OP_AND:  u = U_AND;
      OP_OR:   u = U_OR;
      OP_XOR:  u = U_XOR;
      OP_SHL:  u = U_SHL;
      OP_SHR:  u = U_SHR;
      OP_NOT:  u = U_NOT;
      OP_INC:  u = U_INC;
      OP_DEC:  u = U_DEC;
      OP_CMP:  u = U_CMP;
      default: u = U_HLT;
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/acs_mem.sv
// ----------------------------------------------------------------------------
// acs_mem
// Byte memory with one port, registered read data and per-entry written bits.
// ----------------------------------------------------------------------------
`default_nettype none

module acs_mem
  import acs_pkg::*;
#(
  parameter int MEM_DEPTH = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic              we,
  input  wire logic [7:0]        wdata,
  output logic      [7:0]        rdata
);

  localparam int AW = $clog2(MEM_DEPTH);

  logic [AW-1:0]        idx_tab [ADDR_SPAN];
  logic [AW-1:0]        idx;
  logic [7:0]           mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] written;
  logic [7:0]           data_q;
  logic                 vld_q;

  // address folding onto the memory depth, worked out at elaboration
  for (genvar g = 0; g < ADDR_SPAN; g++) begin : g_idx
    assign idx_tab[g] = AW'(g % MEM_DEPTH);
  end

  assign idx = idx_tab[addr];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[idx] <= wdata;
    end
    data_q <= mem[idx];
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      vld_q   <= 1'b0;
    end else begin
      if (we) begin
        written[idx] <= 1'b1;
      end
      vld_q <= written[idx];
    end
  end

  assign rdata = vld_q ? data_q : 8'd0;

endmodule

`default_nettype wire

>>> hw/rtl/acs_seq.sv
// ----------------------------------------------------------------------------
// acs_seq
// Micro sequencer: step counter, microprogram rom and opcode dispatch.
// ----------------------------------------------------------------------------
`default_nettype none

module acs_seq
  import acs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [1:0] kind,
  input  wire logic [7:0] ir,
  input  wire logic       halted,
  input  wire logic       slot_free,
  output logic            busy,
  output logic            finish,
  output ctrl_t           ctrl
);

  upc_t  upc;
  upc_t  entry;
  ctrl_t word;

  always_comb begin
    unique case (kind_t'(kind))
      KIND_WRITE:  entry = U_WR;
      KIND_READ:   entry = U_RD0;
      KIND_EXEC:   entry = U_EX0;
      KIND_REGRST: entry = U_RST;
      default:     entry = U_DONE;
    endcase
  end

  always_comb begin
    word   = ucode(upc);
    ctrl   = busy ? word : CTRL_NOP;
    finish = busy && (word.seq == SEQ_DONE) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      upc  <= U_DONE;
    end else if (start) begin
      busy <= 1'b1;
      upc  <= entry;
    end else if (busy) begin
      unique case (word.seq)
        SEQ_GOTO:     upc <= word.nxt;
        SEQ_JHALT:    upc <= halted ? U_DONE : word.nxt;
        SEQ_DISPATCH: upc <= dispatch(ir);
        SEQ_DONE: begin
          if (slot_free) begin
            busy <= 1'b0;
          end
        end
        default:      upc <= U_DONE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/acs_dpath.sv
// ----------------------------------------------------------------------------
// acs_dpath
// Register file, alu and address selection driven by the control word.
// ----------------------------------------------------------------------------
`default_nettype none

module acs_dpath
  import acs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [7:0]        req_address,
  input  wire logic [7:0]        req_data,
  input  wire ctrl_t             ctrl,
  input  wire logic [7:0]        rdata,
  output logic      [ADDR_W-1:0] mem_addr,
  output logic                   mem_we,
  output logic      [7:0]        mem_wdata,
  output logic      [7:0]        ir,
  output stat_t                  stat
);

  logic [7:0] acc, b, pc, arg, rd, addr_q, data_q;
  logic       zf, cf, halt;
  emit_t      emit;
  logic [7:0] pc1, pc2, pc_next;
  logic [7:0] alu_res;
  logic       alu_carry;
  logic       alu_zero;
  logic [8:0] sum;

  assign pc1 = pc + 8'd1;
  assign pc2 = pc + 8'd2;
  assign sum = {1'b0, acc} + {1'b0, b};

  always_comb begin
    alu_carry = 1'b0;
    case (ctrl.alu)
      ALU_ARG: alu_res = arg;
      ALU_MEM: alu_res = rdata;
      ALU_ADD: begin
        alu_res   = sum[7:0];
        alu_carry = sum[8];
      end
      ALU_SUB: begin
        alu_res   = acc - b;
        alu_carry = (acc < b);
      end
      ALU_AND: alu_res = acc & b;
      ALU_OR:  alu_res = acc | b;
      ALU_XOR: alu_res = acc ^ b;
      ALU_SHL: begin
        alu_res   = {acc[6:0], 1'b0};
        alu_carry = acc[7];
      end
      ALU_SHR: begin
        alu_res   = {1'b0, acc[7:1]};
        alu_carry = acc[0];
      end
      ALU_NOT: alu_res = ~acc;
      ALU_INC: begin
        alu_res   = acc + 8'd1;
        alu_carry = (acc == 8'hFF);
      end
      ALU_DEC: alu_res = acc - 8'd1;
      ALU_CMP: alu_res = acc - b;
      default: alu_res = acc;
    endcase
    alu_zero = (alu_res == 8'd0);
  end

  always_comb begin
    case (ctrl.pc_sel)
      PC_STEP1: pc_next = pc1;
      PC_STEP2: pc_next = pc2;
      PC_JUMP:  pc_next = arg;
      PC_JZ:    pc_next = zf ? arg : pc2;
      PC_JNZ:   pc_next = alu_zero ? pc2 : arg;
      default:  pc_next = pc;
    endcase
  end

  always_comb begin
    case (ctrl.asel)
      ASEL_PC:  mem_addr = pc;
      ASEL_PC1: mem_addr = pc1;
      ASEL_ARG: mem_addr = arg;
      default:  mem_addr = addr_q;
    endcase
    mem_we    = ctrl.mem_we;
    mem_wdata = (ctrl.wsel == WSEL_ACC) ? acc : data_q;
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.regs_clr) begin
      acc  <= 8'd0;
      b    <= 8'd0;
      pc   <= 8'd0;
      zf   <= 1'b0;
      cf   <= 1'b0;
      halt <= 1'b0;
    end else begin
      if (ctrl.acc_ld) begin
        acc <= alu_res;
      end
      if (ctrl.zero_ld) begin
        zf <= alu_zero;
      end
      if (ctrl.carry_ld && alu_carry) begin
        cf <= 1'b1;
      end
      if (ctrl.b_ld) begin
        b <= arg;
      end
      if (ctrl.halt_set) begin
        halt <= 1'b1;
      end
      pc <= pc_next;
    end
  end

  // per-request results
  always_ff @(posedge clk) begin
    if (rst) begin
      rd   <= 8'd0;
      emit <= EMIT_NONE;
    end else if (start) begin
      rd   <= 8'd0;
      emit <= EMIT_NONE;
    end else begin
      if (ctrl.rd_ld) begin
        rd <= rdata;
      end
      if (ctrl.emit != EMIT_NONE) begin
        emit <= ctrl.emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      addr_q <= req_address;
      data_q <= req_data;
    end
    if (ctrl.ir_ld) begin
      ir <= rdata;
    end
    if (ctrl.arg_ld) begin
      arg <= rdata;
    end
  end

  assign stat = '{rd: rd, emit: emit, halt: halt, pc: pc, acc: acc, zf: zf, cf: cf};

endmodule

`default_nettype wire

>>> hw/rtl/accumulator_cpu_step_top.sv
// ----------------------------------------------------------------------------
// accumulator_cpu_step_top
// 8-bit accumulator processor stepped one request at a time.
// ----------------------------------------------------------------------------
// Each request writes or reads a memory byte, clears the registers or executes
// the instruction at pc, and gives one result with the register state after
// it. Requests are taken one at a time; in_ready rises again in the cycle that
// the result is registered. An executed instruction fetches its opcode, then
// its operand, then runs its routine (a memory load then reads its data; while
// halted it ends without fetching); fetches and data accesses all share the
// single memory port and its registered read. A waiting result does not stop
// work on the next request until that request's own result is ready.
`default_nettype none

module accumulator_cpu_step_top
  import acs_pkg::*;
#(
  parameter int MEM_DEPTH = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] kind,
  input  wire logic [7:0] address,
  input  wire logic [7:0] data,
  output logic            res_valid,
  input  wire logic       res_ready,
  output logic      [7:0] read_data,
  output logic            out_valid,
  output logic            out_is_char,
  output logic      [7:0] out_value,
  output logic            halted,
  output logic      [7:0] prog_counter,
  output logic      [7:0] accumulator,
  output logic            zero_out,
  output logic            carry_out
);

  logic              start;
  logic              busy;
  logic              finish;
  logic              slot_free;
  ctrl_t             ctrl;
  stat_t             stat;
  logic [7:0]        ir;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_rdata;

  assign in_ready  = !busy;
  assign start     = in_valid && in_ready;
  assign slot_free = !res_valid || res_ready;

  acs_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .kind      (kind),
    .ir        (ir),
    .halted    (stat.halt),
    .slot_free (slot_free),
    .busy      (busy),
    .finish    (finish),
    .ctrl      (ctrl)
  );

  acs_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .req_address (address),
    .req_data    (data),
    .ctrl        (ctrl),
    .rdata       (mem_rdata),
    .mem_addr    (mem_addr),
    .mem_we      (mem_we),
    .mem_wdata   (mem_wdata),
    .ir          (ir),
    .stat        (stat)
  );

  acs_mem #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .addr  (mem_addr),
    .we    (mem_we),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (finish) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      read_data    <= stat.rd;
      out_valid    <= (stat.emit != EMIT_NONE);
      out_is_char  <= (stat.emit == EMIT_CHAR);
      out_value    <= (stat.emit != EMIT_NONE) ? stat.acc : 8'd0;
      halted       <= stat.halt;
      prog_counter <= stat.pc;
      accumulator  <= stat.acc;
      zero_out     <= stat.zf;
      carry_out    <= stat.cf;
    end
  end

endmodule

`default_nettype wire
